>>> rtl/mrtu_pkg.sv
package mrtu_pkg;

    localparam int FRAME_LEN = 8;
    localparam int HDR_LEN   = 6;
    localparam int CNT_W     = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FC_WRITE_COIL   = 8'h05;
    localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
    localparam logic [15:0] READ_QUANTITY   = 16'h0001;

    localparam logic [7:0]  DEV_ADDR_RESET  = 8'h01;

    localparam logic [CNT_W-1:0] CNT_CRC_LO = CNT_W'(HDR_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        OP_READ_HOLDING = 2'd0,
        OP_WRITE_COIL   = 2'd1,
        OP_WRITE_SINGLE = 2'd2
    } t_opcode;

    // one CRC-16/MODBUS byte update, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

endpackage

>>> rtl/modbus_rtu_request_framer_unit.sv
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------
// request   | in        | start / busy              | i_opcode, i_reg_addr, i_value
// frame     | out       | o_strobe (no backpressure)| o_out_byte, o_last
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (device address)
//
// One frame word leaves per cycle, the header from the frame shift register, the
// CRC from r_crc; the CRC is folded in one byte per cycle as the header goes out.
// The first word is on the outputs from the edge after the start edge; busy drops
// while the CRC low word is out, so back to back requests give a gapless stream.
// The receiver cannot stall; each word stands for one cycle. Opcode 3 is taken and
// dropped. Reset (sync, active low) idles the sequencer, device address back to 1.
module modbus_rtu_request_framer_unit
    import mrtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_reg_addr,
    input  logic [15:0] i_value,
    output logic        o_strobe,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic                   r_active;
    logic [CNT_W-1:0]       r_cnt;
    logic [HDR_LEN*8-1:0]   r_frame;
    logic [15:0]            r_crc;
    logic [7:0]             r_dev_addr;
    logic                   r_strobe;
    logic [7:0]             r_byte;
    logic                   r_last;

    logic                   accept;
    logic                   op_ok;
    logic [7:0]             fc;
    logic [15:0]            word;
    logic [7:0]             cur_byte;
    logic [7:0]             n_byte;

    assign busy        = r_active && (r_cnt != CNT_LAST);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        op_ok = 1'b1;
        fc    = FC_READ_HOLDING;
        word  = i_value;
        unique case (i_opcode)
            OP_READ_HOLDING: begin
                fc   = FC_READ_HOLDING;
                word = READ_QUANTITY;
            end
            OP_WRITE_COIL:   fc = FC_WRITE_COIL;
            OP_WRITE_SINGLE: fc = FC_WRITE_SINGLE;
            default:         op_ok = 1'b0;
        endcase
    end

    assign cur_byte = r_frame[HDR_LEN*8-1 -: 8];

    always_comb begin
        if (r_cnt == CNT_LAST) begin
            n_byte = r_crc[15:8];
        end else if (r_cnt == CNT_CRC_LO) begin
            n_byte = r_crc[7:0];
        end else begin
            n_byte = cur_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_cnt      <= '0;
            r_strobe   <= 1'b0;
            r_last     <= 1'b0;
            r_dev_addr <= DEV_ADDR_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_dev_addr <= i_cfg_data;
            end
            r_strobe <= r_active;
            r_last   <= r_active && (r_cnt == CNT_LAST);
            if (accept) begin
                r_active <= op_ok;
                r_cnt    <= '0;
            end else if (r_active) begin
                if (r_cnt == CNT_LAST) begin
                    r_active <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (accept) begin
            r_frame <= {r_dev_addr, fc, i_reg_addr, word};
            r_crc   <= CRC_INIT;
        end else if (r_active && (r_cnt < CNT_CRC_LO)) begin
            r_frame <= {r_frame[HDR_LEN*8-9:0], 8'h00};
            r_crc   <= crc16_byte(r_crc, cur_byte);
        end
    end

    assign o_strobe   = r_strobe;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

`ifndef SYNTHESIS
    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last word without strobe");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op_ok) |-> ##2 (o_strobe && !o_last))
        else $error("frame did not start two cycles after accept");

    a_last_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_last)
        else $error("two last words in a row");

    a_busy_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_active)
        else $error("busy while sequencer idle");

    a_drop_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !op_ok) |=> !r_active)
        else $error("undefined opcode started a frame");
`endif

endmodule
